@@ rtl/bmls_pkg.sv @@
// shared types and constants of the bump map light shader
`default_nettype none
package bmls_pkg;

    // width of the light distance terms dx and dy
    localparam int D_W = 10;
    // width of one height difference
    localparam int H_W = 9;
    // signed width of the dot sum, covers every light height in range
    localparam int DOT_W = 21;
    // unsigned width of the squared distance sum
    localparam int DIST_W = 20;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_XX,
        MUL_YY,
        MUL_XH,
        MUL_YH,
        MUL_DR
    } mul_op_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_DIST,
        ACC_DOT
    } acc_op_t;

    typedef struct packed {
        logic    load;
        mul_op_t mul_op;
        acc_op_t acc_op;
        logic    check;
        logic    div_init;
        logic    div_step;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic dot_pos;
        logic div_last;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

@@ rtl/bmls_ctrl.sv @@
// sequencer of the shader: issues multiplies, divider steps and the output load
`default_nettype none
module bmls_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  bmls_pkg::status_t     status,
    output bmls_pkg::cmd_t        cmd
);
    import bmls_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_M_XX,
        S_M_YY,
        S_M_XH,
        S_M_YH,
        S_ACC,
        S_CHECK,
        S_DIV,
        S_M_DR,
        S_SAT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.mul_op   = MUL_NONE;
        cmd.acc_op   = ACC_NONE;
        in_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_M_XX;
                end
            end
            S_M_XX:
            begin
                cmd.mul_op = MUL_XX;
                state_next = S_M_YY;
            end
            S_M_YY:
            begin
                cmd.mul_op = MUL_YY;
                cmd.acc_op = ACC_DIST;
                state_next = S_M_XH;
            end
            S_M_XH:
            begin
                cmd.mul_op = MUL_XH;
                cmd.acc_op = ACC_DIST;
                state_next = S_M_YH;
            end
            S_M_YH:
            begin
                cmd.mul_op = MUL_YH;
                cmd.acc_op = ACC_DOT;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_op = ACC_DOT;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check    = 1'b1;
                cmd.div_init = 1'b1;
                // a dark pixel skips the reciprocal entirely
                state_next   = status.dot_pos ? S_DIV : S_SAT;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_M_DR;
                end
            end
            S_M_DR:
            begin
                cmd.mul_op = MUL_DR;
                state_next = S_SAT;
            end
            S_SAT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/bmls_dp.sv @@
// datapath: pixel counters, shared multiplier, serial reciprocal divider, output register
`default_nettype none
module bmls_dp #(
    parameter int MAP_WIDTH        = 128,
    parameter int MAP_HEIGHT       = 128,
    parameter int LIGHT_HEIGHT_LOG = 6,
    parameter int RECIP_FRAC       = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  bmls_pkg::cmd_t         cmd,
    output bmls_pkg::status_t      status,
    input  wire logic signed [8:0] light_x,
    input  wire logic signed [8:0] light_y,
    input  wire logic signed [7:0] height_here,
    input  wire logic signed [7:0] height_right,
    input  wire logic signed [7:0] height_below,
    output logic             [7:0] brightness,
    output logic                   frame_end,
    output logic                   out_valid,
    input  wire logic              out_ready
);
    import bmls_pkg::*;

    localparam int COL_W  = (MAP_WIDTH  > 1) ? $clog2(MAP_WIDTH)  : 1;
    localparam int ROW_W  = (MAP_HEIGHT > 1) ? $clog2(MAP_HEIGHT) : 1;
    localparam int B_W    = RECIP_FRAC + 2;
    localparam int P_W    = DOT_W + B_W;
    localparam int Q_W    = RECIP_FRAC + 1;
    localparam int DV_W   = DIST_W - LIGHT_HEIGHT_LOG;
    localparam int CNT_W  = $clog2(RECIP_FRAC + 1);

    logic [COL_W-1:0]        col_reg;
    logic [ROW_W-1:0]        row_reg;
    logic signed [D_W-1:0]   dx_reg;
    logic signed [D_W-1:0]   dy_reg;
    logic signed [H_W-1:0]   dh_reg;
    logic signed [H_W-1:0]   dv_reg;
    logic                    last_reg;
    logic signed [DOT_W-1:0] dot_reg;
    logic [DIST_W-1:0]       dist_reg;
    logic signed [P_W-1:0]   prod_reg;
    logic                    pos_reg;
    logic [DV_W-1:0]         div_reg;
    logic [DV_W-1:0]         rem_reg;
    logic [Q_W-1:0]          quo_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    out_valid_reg;
    logic [7:0]              bright_reg;
    logic                    frame_end_reg;

    logic                    last_col;
    logic                    last_row;
    logic signed [D_W-1:0]   dx_next;
    logic signed [D_W-1:0]   dy_next;
    logic signed [DOT_W-1:0] mul_a;
    logic signed [B_W-1:0]   mul_b;
    logic signed [P_W-1:0]   prod_next;
    logic [DV_W:0]           trial;
    logic                    q_bit;
    logic [P_W-RECIP_FRAC-1:0] scaled;
    logic [7:0]              bright_next;

    assign last_col = (col_reg == COL_W'(MAP_WIDTH - 1));
    assign last_row = (row_reg == ROW_W'(MAP_HEIGHT - 1));
    assign dx_next  = D_W'(light_x) - D_W'(col_reg);
    assign dy_next  = D_W'(light_y) - D_W'(row_reg);

    // operand selection for the single shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            MUL_XX:
            begin
                mul_a = DOT_W'(dx_reg);
                mul_b = B_W'(dx_reg);
            end
            MUL_YY:
            begin
                mul_a = DOT_W'(dy_reg);
                mul_b = B_W'(dy_reg);
            end
            MUL_XH:
            begin
                mul_a = DOT_W'(dx_reg);
                mul_b = B_W'(dh_reg);
            end
            MUL_YH:
            begin
                mul_a = DOT_W'(dy_reg);
                mul_b = B_W'(dv_reg);
            end
            MUL_DR:
            begin
                mul_a = dot_reg;
                mul_b = signed'(B_W'(quo_reg));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = P_W'(mul_a) * P_W'(mul_b);

    // restoring step, the dividend is a single one bit ahead of zeros
    assign trial = {rem_reg, (cnt_reg == '0)};
    assign q_bit = (trial >= {1'b0, div_reg});

    assign scaled      = prod_reg[P_W-1:RECIP_FRAC];
    assign bright_next = !pos_reg ? 8'd0 :
                         (|scaled[P_W-RECIP_FRAC-1:8]) ? 8'd255 : scaled[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            dh_reg   <= H_W'(height_here) - H_W'(height_right);
            dv_reg   <= H_W'(height_here) - H_W'(height_below);
            last_reg <= last_col && last_row;
            dot_reg  <= DOT_W'(1) <<< (LIGHT_HEIGHT_LOG + 8);
            dist_reg <= DIST_W'(1) << (2 * LIGHT_HEIGHT_LOG);
        end
        else
        begin
            case (cmd.acc_op)
                ACC_DIST: dist_reg <= dist_reg + prod_reg[DIST_W-1:0];
                ACC_DOT:  dot_reg  <= dot_reg + prod_reg[DOT_W-1:0];
                default:  ;
            endcase
        end
        if (cmd.mul_op != MUL_NONE)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.check)
        begin
            pos_reg <= (dot_reg > 0);
        end
        if (cmd.div_init)
        begin
            div_reg <= DV_W'(dist_reg >> LIGHT_HEIGHT_LOG);
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= q_bit ? DV_W'(trial - {1'b0, div_reg}) : trial[DV_W-1:0];
            quo_reg <= {quo_reg[Q_W-2:0], q_bit};
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        if (cmd.out_load)
        begin
            bright_reg    <= bright_next;
            frame_end_reg <= last_reg;
        end
    end

    assign status.dot_pos  = (dot_reg > 0);
    assign status.div_last = (cnt_reg == CNT_W'(RECIP_FRAC));
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign brightness = bright_reg;
    assign frame_end  = frame_end_reg;

endmodule
`default_nettype wire

@@ rtl/bump_map_light_shader_core.sv @@
// top level of the bump map light shader with its register port
`default_nettype none
// Shades a height map streamed in raster order under a point light. Each input
// item carries a pixel height and its right and lower neighbour heights; one
// brightness item comes out per pixel, with frame_end set on the last pixel.
// One item is worked at a time: five products (four for a dark pixel) go
// through a single shared multiplier and the reciprocal of the distance term
// comes from a restoring divider taking one quotient bit per cycle. The
// finished result sits in an output register and the sequencer goes back to
// its idle state, where it takes the next item, once that register is
// loaded; a result still waiting when the next one is finished holds the
// sequencer. Registers: light_x at byte address 0, light_y at 4, both 9-bit
// signed, reset 64.
module bump_map_light_shader_core #(
    parameter int MAP_WIDTH        = 128,
    parameter int MAP_HEIGHT       = 128,
    parameter int LIGHT_HEIGHT_LOG = 6,
    parameter int RECIP_FRAC       = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  height_here,
    input  wire logic [7:0]  height_right,
    input  wire logic [7:0]  height_below,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [7:0]  brightness,
    output logic             frame_end
);
    import bmls_pkg::*;

    localparam logic REG_LIGHT_X = 1'b0;
    localparam logic REG_LIGHT_Y = 1'b1;

    logic signed [8:0] light_x_reg;
    logic signed [8:0] light_y_reg;
    logic              wr_en;
    cmd_t              cmd;
    status_t           status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_x_reg <= 9'sd64;
            light_y_reg <= 9'sd64;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_LIGHT_X: light_x_reg <= signed'(pwdata[8:0]);
                REG_LIGHT_Y: light_y_reg <= signed'(pwdata[8:0]);
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_LIGHT_X: prdata = {{23{light_x_reg[8]}}, light_x_reg};
            REG_LIGHT_Y: prdata = {{23{light_y_reg[8]}}, light_y_reg};
            default:     prdata = '0;
        endcase
    end

    bmls_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bmls_dp #(
        .MAP_WIDTH        (MAP_WIDTH),
        .MAP_HEIGHT       (MAP_HEIGHT),
        .LIGHT_HEIGHT_LOG (LIGHT_HEIGHT_LOG),
        .RECIP_FRAC       (RECIP_FRAC)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .light_x      (light_x_reg),
        .light_y      (light_y_reg),
        .height_here  (signed'(height_here)),
        .height_right (signed'(height_right)),
        .height_below (signed'(height_below)),
        .brightness   (brightness),
        .frame_end    (frame_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready)
    );

endmodule
`default_nettype wire

@@ rtl/bmls_checker.sv @@
// port level checks of the shader and their binding to the top level
`default_nettype none
module bmls_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       pready,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] brightness,
    input wire logic       frame_end
);

    // a waiting result holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(brightness) && $stable(frame_end))
        else $error("result changed while stalled");

    // one item at a time: busy right after an accepted item
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while busy");

    // no result can appear the cycle after an item is taken
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (!out_valid || out_ready) |=> !out_valid)
        else $error("result appeared too early");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("register port not ready");

endmodule

bind bump_map_light_shader_core bmls_checker u_bmls_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .brightness (brightness),
    .frame_end  (frame_end)
);
`default_nettype wire
